[design/calendar_rtc_with_alarm_unit_assert.svh]
// assertion macros for the calendar rtc with alarm
`ifndef CALENDAR_RTC_WITH_ALARM_UNIT_ASSERT_SVH
`define CALENDAR_RTC_WITH_ALARM_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CALR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("calr same-cycle check failed");
`define CALR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("calr next-cycle check failed");
`else
`define CALR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CALR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/calr_pkg.sv]
// shared types, codes and calendar functions for the calendar rtc
package calr_pkg;

    localparam int YEAR_BITS = 12;
    localparam int CELL_W    = YEAR_BITS;
    localparam int N_CELLS   = 7;

    typedef logic [CELL_W-1:0] t_cell;

    // cell positions along the chain
    localparam int CELL_SEC   = 0;
    localparam int CELL_MIN   = 1;
    localparam int CELL_HOUR  = 2;
    localparam int CELL_DOW   = 3;
    localparam int CELL_DAY   = 4;
    localparam int CELL_MONTH = 5;
    localparam int CELL_YEAR  = 6;

    // event mask bit positions
    localparam int EV_SECOND = 0;
    localparam int EV_MINUTE = 1;
    localparam int EV_HOUR   = 2;
    localparam int EV_DAY    = 3;
    localparam int EV_MONTH  = 4;
    localparam int EV_YEAR   = 5;
    localparam int EV_ALARM  = 6;

    localparam logic [7:0] MASK_SIX   = 8'h3F;
    localparam logic [7:0] MASK_FIVE  = 8'h1F;
    localparam logic [7:0] MASK_FOUR  = 8'h0F;
    localparam logic [7:0] MASK_THREE = 8'h07;
    localparam logic [7:0] MASK_BYTE  = 8'hFF;

    localparam int SEC_LAST   = 59;
    localparam int MIN_LAST   = 59;
    localparam int HOUR_LAST  = 23;
    localparam int DOW_LAST   = 6;
    localparam int MONTH_LAST = 12;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ADDR_SEC     = 3'd0,
        ADDR_MIN     = 3'd1,
        ADDR_HOUR    = 3'd2,
        ADDR_DOW     = 3'd3,
        ADDR_DAY     = 3'd4,
        ADDR_MONTH   = 3'd5,
        ADDR_YEAR_LO = 3'd6,
        ADDR_YEAR_HI = 3'd7
    } t_addr;

    typedef enum logic [1:0] {
        CFG_ALARM_HOUR   = 2'd0,
        CFG_ALARM_MIN    = 2'd1,
        CFG_ALARM_HOUR_EN = 2'd2,
        CFG_ALARM_MIN_EN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic inc;
        logic wr_en;
    } t_cell_ctrl;

    // gregorian leap rule; the mod 25 test folds the year using 1024 = -1 (mod 25)
    function automatic logic is_leap(t_cell y);
        logic [9:0]  lo;
        logic [5:0]  hi;
        logic [10:0] x;
        logic [21:0] prod;
        logic [6:0]  q;
        logic [10:0] back;
        logic        m25;
        lo   = 10'(y);
        hi   = 6'(y >> 10);
        x    = 11'(lo) + 11'd75 - 11'(hi);
        prod = 22'(x) * 22'd1311;
        q    = 7'(prod >> 15);
        back = 11'({q, 4'b0000}) + 11'({q, 3'b000}) + 11'(q);
        m25  = (back == x);
        return (y[1:0] == 2'b00) && (!m25 || (y[3:0] == 4'b0000));
    endfunction

    // days in a month, zero for a month code that means nothing
    function automatic logic [4:0] month_len(logic [3:0] m, t_cell y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[design/calr_cell.sv]
// one counter cell of the calendar chain
module calr_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  calr_pkg::t_cell_ctrl i_ctrl,
    input  calr_pkg::t_cell    i_wr_data,
    input  calr_pkg::t_cell    i_limit,
    input  calr_pkg::t_cell    i_first,
    output calr_pkg::t_cell    o_value,
    output calr_pkg::t_cell    o_next,
    output logic               o_carry
);
    import calr_pkg::*;

    t_cell r_value;
    t_cell n_value;
    logic  w_below;

    assign w_below = (r_value < i_limit);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.wr_en) begin
            n_value = i_wr_data;
        end else if (i_ctrl.inc) begin
            n_value = w_below ? r_value + t_cell'(1) : i_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= i_first;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_next  = n_value;
    assign o_carry = i_ctrl.inc && !w_below;

endmodule

[design/calendar_rtc_with_alarm_unit.sv]
// top level of the calendar rtc with alarm: cell chain, alarm match, result register
//
//  channel   signals                                          direction
//  -------   -----------------------------------------------  ---------
//  in        i_valid / o_ready, i_cmd, i_reg_addr, i_write_data  into block
//  out       o_valid / i_ready, o_read_data, o_event_mask        out of block
//  config    i_cfg_we, i_cfg_index, i_cfg_data                   into block
//
//  one item per cycle unless stalled: a tick crosses every cell in the cycle it is taken
//  the result appears in the cycle after acceptance, held in the output register
//  a new item is taken whenever the output register is empty or being emptied
//  synchronous active-low reset: 00:00:00, weekday 0, day 1, month 1, year 0, alarm off
module calendar_rtc_with_alarm_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_cmd,
    input  logic [2:0]            i_reg_addr,
    input  logic [7:0]            i_write_data,
    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_read_data,
    output logic [6:0]            o_event_mask,
    // alarm configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [5:0]            i_cfg_data
);
    import calr_pkg::*;

    `include "calendar_rtc_with_alarm_unit_assert.svh"

    // alarm registers
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alarm_min;
    logic       r_alarm_hour_en;
    logic       r_alarm_min_en;

    // result register
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic [6:0] r_event_mask;
    logic [7:0] n_read_data;
    logic [6:0] n_event_mask;

    // chain wiring
    t_cell      c_value [N_CELLS];
    t_cell      c_next  [N_CELLS];
    logic       c_carry [N_CELLS];
    t_cell_ctrl c_ctrl  [N_CELLS];
    t_cell      c_limit [N_CELLS];
    t_cell      c_first [N_CELLS];
    t_cell      w_wr_data;

    logic       w_acc;
    logic       w_tick;
    logic       w_write;
    logic       w_read;
    logic       w_alarm;

    // take an item when the result slot is free or draining this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_tick  = 1'b0;
        w_write = 1'b0;
        w_read  = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_TICK:  w_tick  = w_acc;
            CMD_WRITE: w_write = w_acc;
            CMD_READ:  w_read  = w_acc;
            default:   ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_hour    <= '0;
            r_alarm_min     <= '0;
            r_alarm_hour_en <= 1'b0;
            r_alarm_min_en  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALARM_HOUR:    r_alarm_hour    <= 5'(i_cfg_data);
                CFG_ALARM_MIN:     r_alarm_min     <= i_cfg_data;
                CFG_ALARM_HOUR_EN: r_alarm_hour_en <= i_cfg_data[0];
                CFG_ALARM_MIN_EN:  r_alarm_min_en  <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // limits and reload values per cell; the day limit follows the current month and year
    always_comb begin
        c_limit[CELL_SEC]   = t_cell'(SEC_LAST);
        c_limit[CELL_MIN]   = t_cell'(MIN_LAST);
        c_limit[CELL_HOUR]  = t_cell'(HOUR_LAST);
        c_limit[CELL_DOW]   = t_cell'(DOW_LAST);
        c_limit[CELL_DAY]   = t_cell'(month_len(4'(c_value[CELL_MONTH]), c_value[CELL_YEAR]));
        c_limit[CELL_MONTH] = t_cell'(MONTH_LAST);
        // year has no limit of its own: all ones reloads zero, i.e. it wraps
        c_limit[CELL_YEAR]  = '1;

        c_first[CELL_SEC]   = '0;
        c_first[CELL_MIN]   = '0;
        c_first[CELL_HOUR]  = '0;
        c_first[CELL_DOW]   = '0;
        c_first[CELL_DAY]   = t_cell'(1);
        c_first[CELL_MONTH] = t_cell'(1);
        c_first[CELL_YEAR]  = '0;
    end

    // carry path: tick enters seconds, each carry steps the neighbour;
    // day of week sits beside day of month on the hour carry
    always_comb begin
        c_ctrl[CELL_SEC].inc   = w_tick;
        c_ctrl[CELL_MIN].inc   = c_carry[CELL_SEC];
        c_ctrl[CELL_HOUR].inc  = c_carry[CELL_MIN];
        c_ctrl[CELL_DOW].inc   = c_carry[CELL_HOUR];
        c_ctrl[CELL_DAY].inc   = c_carry[CELL_HOUR];
        c_ctrl[CELL_MONTH].inc = c_carry[CELL_DAY];
        c_ctrl[CELL_YEAR].inc  = c_carry[CELL_MONTH];

        for (int k = 0; k < N_CELLS; k++) begin
            c_ctrl[k].wr_en = 1'b0;
        end
        w_wr_data = '0;
        unique case (t_addr'(i_reg_addr))
            ADDR_SEC: begin
                c_ctrl[CELL_SEC].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_SIX);
            end
            ADDR_MIN: begin
                c_ctrl[CELL_MIN].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_SIX);
            end
            ADDR_HOUR: begin
                c_ctrl[CELL_HOUR].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_FIVE);
            end
            ADDR_DOW: begin
                c_ctrl[CELL_DOW].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_THREE);
            end
            ADDR_DAY: begin
                c_ctrl[CELL_DAY].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_FIVE);
            end
            ADDR_MONTH: begin
                c_ctrl[CELL_MONTH].wr_en = w_write;
                w_wr_data = t_cell'(i_write_data & MASK_FOUR);
            end
            ADDR_YEAR_LO: begin
                c_ctrl[CELL_YEAR].wr_en = w_write;
                w_wr_data = (c_value[CELL_YEAR] & ~t_cell'(MASK_BYTE))
                          | t_cell'(i_write_data);
            end
            ADDR_YEAR_HI: begin
                // upper year bits only; nothing lands if the year is a single byte
                c_ctrl[CELL_YEAR].wr_en = w_write;
                w_wr_data = (c_value[CELL_YEAR] & t_cell'(MASK_BYTE))
                          | (t_cell'(i_write_data) << 8);
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        calr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (c_ctrl[g]),
            .i_wr_data (w_wr_data),
            .i_limit   (c_limit[g]),
            .i_first   (c_first[g]),
            .o_value   (c_value[g]),
            .o_next    (c_next[g]),
            .o_carry   (c_carry[g])
        );
    end

    // alarm: on a minute rollover, enabled fields against the updated time
    assign w_alarm = c_carry[CELL_SEC] && (r_alarm_hour_en || r_alarm_min_en)
                   && (!r_alarm_hour_en || (c_next[CELL_HOUR] == t_cell'(r_alarm_hour)))
                   && (!r_alarm_min_en  || (c_next[CELL_MIN]  == t_cell'(r_alarm_min)));

    always_comb begin
        n_event_mask = '0;
        n_event_mask[EV_SECOND] = w_tick;
        n_event_mask[EV_MINUTE] = c_carry[CELL_SEC];
        n_event_mask[EV_HOUR]   = c_carry[CELL_MIN];
        n_event_mask[EV_DAY]    = c_carry[CELL_HOUR];
        n_event_mask[EV_MONTH]  = c_carry[CELL_DAY];
        n_event_mask[EV_YEAR]   = c_carry[CELL_MONTH];
        n_event_mask[EV_ALARM]  = w_alarm;
    end

    // read mux
    always_comb begin
        n_read_data = '0;
        if (w_read) begin
            unique case (t_addr'(i_reg_addr))
                ADDR_SEC:     n_read_data = 8'(c_value[CELL_SEC]);
                ADDR_MIN:     n_read_data = 8'(c_value[CELL_MIN]);
                ADDR_HOUR:    n_read_data = 8'(c_value[CELL_HOUR]);
                ADDR_DOW:     n_read_data = 8'(c_value[CELL_DOW]);
                ADDR_DAY:     n_read_data = 8'(c_value[CELL_DAY]);
                ADDR_MONTH:   n_read_data = 8'(c_value[CELL_MONTH]);
                ADDR_YEAR_LO: n_read_data = 8'(c_value[CELL_YEAR]);
                ADDR_YEAR_HI: n_read_data = 8'(c_value[CELL_YEAR] >> 8);
                default:      n_read_data = '0;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_read_data  <= n_read_data;
            r_event_mask <= n_event_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_event_mask = r_event_mask;

    // checks
    `CALR_ASSERT_NEXT(a_acc_gives_item, i_clk, i_rst_n, w_acc, o_valid)
    `CALR_ASSERT_NEXT(a_sec_wraps, i_clk, i_rst_n, c_carry[CELL_SEC], c_value[CELL_SEC] == '0)
    `CALR_ASSERT_SAME(a_read_or_event, i_clk, i_rst_n, o_valid,
        (o_read_data == '0) || (o_event_mask == '0))
    `CALR_ASSERT_SAME(a_carry_ordered, i_clk, i_rst_n, o_valid,
        (!o_event_mask[EV_MINUTE] || o_event_mask[EV_SECOND])
        && (!o_event_mask[EV_HOUR] || o_event_mask[EV_MINUTE])
        && (!o_event_mask[EV_DAY] || o_event_mask[EV_HOUR])
        && (!o_event_mask[EV_MONTH] || o_event_mask[EV_DAY])
        && (!o_event_mask[EV_YEAR] || o_event_mask[EV_MONTH])
        && (!o_event_mask[EV_ALARM] || o_event_mask[EV_MINUTE]))

endmodule
